@@ design/rpfp_pkg.sv @@
// Shared types, constants and frame codes of the presence radar frame parser.
package rpfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int HEAD_DEPTH  = 20;
  localparam int CNT_W       = 5;
  localparam int WORD_W      = 16;
  localparam int TIME_W      = 13;
  localparam int KIND_W      = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] CNT_MAX      = 5'd31;
  localparam logic [CNT_W-1:0] LEN_TERM2    = 5'd2;
  localparam logic [CNT_W-1:0] LEN_TERM4    = 5'd4;
  localparam logic [CNT_W-1:0] LEN_TYPE     = 5'd3;
  localparam logic [CNT_W-1:0] LEN_TARGET   = 5'd5;
  localparam logic [CNT_W-1:0] LEN_SETTINGS = 5'd20;

  localparam logic [KIND_W-1:0] KIND_ABSENCE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVING     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATIONARY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SETTINGS   = 2'd3;

  localparam logic [15:0] TERM_SHORT = 16'h5555;
  localparam logic [31:0] TERM_LONG  = 32'h04030201;

  localparam logic [BYTE_W-1:0] HDR_TARGET = 8'hAA;
  localparam logic [BYTE_W-1:0] TYPE_NONE  = 8'h00;
  localparam logic [BYTE_W-1:0] TYPE_MOVE  = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_STILL = 8'h02;
  localparam logic [BYTE_W-1:0] HDR_CMD0   = 8'hFD;
  localparam logic [BYTE_W-1:0] HDR_CMD1   = 8'hFC;
  localparam logic [BYTE_W-1:0] HDR_CMD2   = 8'hFB;
  localparam logic [BYTE_W-1:0] HDR_CMD3   = 8'hFA;
  localparam logic [BYTE_W-1:0] CMD_READ   = 8'h73;
  localparam logic [BYTE_W-1:0] CMD_ACK    = 8'h01;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [WORD_W-1:0] DIV10_MUL   = 16'hCCCD;
  localparam int                DIV10_SHIFT = 19;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] distance;
    logic [WORD_W-1:0] max_motion_gate;
    logic [WORD_W-1:0] min_motion_gate;
    logic [WORD_W-1:0] max_presence_gate;
    logic [WORD_W-1:0] min_presence_gate;
    logic [WORD_W-1:0] time_raw;
  } rec_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

@@ design/radar_presence_frame_parser_unit.sv @@
// Top level of the presence radar frame parser.
// Takes one UART byte per cycle while in_stall is low. A frame ends on 55 55
// or 04 03 02 01 and is then classified as absence, moving, stationary or
// settings reply; a result is registered in the frame queue and then in the
// output register. Unmatched or short frames give no result. in_stall rises
// only while the QUEUE_DEPTH-entry queue of classified frames between front
// and back end is full, which happens only under a stalled output.
module radar_presence_frame_parser_unit #(
  parameter int QUEUE_DEPTH = rpfp_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rpfp_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rpfp_pkg::KIND_W-1:0]  out_packet_kind,
  output logic                         out_presence,
  output logic                         out_motion,
  output logic [rpfp_pkg::WORD_W-1:0]  out_distance,
  output logic [rpfp_pkg::WORD_W-1:0]  out_max_motion_gate,
  output logic [rpfp_pkg::WORD_W-1:0]  out_min_motion_gate,
  output logic [rpfp_pkg::WORD_W-1:0]  out_max_presence_gate,
  output logic [rpfp_pkg::WORD_W-1:0]  out_min_presence_gate,
  output logic [rpfp_pkg::TIME_W-1:0]  out_unoccupied_time
);
  import rpfp_pkg::*;

  logic      accept, push, pop;
  rec_t      wr_rec, rd_rec;
  q_status_t q_status;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  rpfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .push    (push),
    .rec     (wr_rec)
  );

  rpfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .status (q_status)
  );

  rpfp_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_status              (q_status),
    .q_rec                 (rd_rec),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_packet_kind       (out_packet_kind),
    .out_presence          (out_presence),
    .out_motion            (out_motion),
    .out_distance          (out_distance),
    .out_max_motion_gate   (out_max_motion_gate),
    .out_min_motion_gate   (out_min_motion_gate),
    .out_max_presence_gate (out_max_presence_gate),
    .out_min_presence_gate (out_min_presence_gate),
    .out_unoccupied_time   (out_unoccupied_time)
  );

endmodule

@@ design/rpfp_front.sv @@
// Front end: frame buffering, end-of-frame detection and classification.
module rpfp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [rpfp_pkg::BYTE_W-1:0] rx_byte,
  output logic                       push,
  output rpfp_pkg::rec_t             rec
);
  import rpfp_pkg::*;

  logic [BYTE_W-1:0] head_r [HEAD_DEPTH];
  logic [BYTE_W-1:0] hv     [HEAD_DEPTH];
  logic [31:0]       recent_r, recent_nxt, recent_new;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic              ended, is_target, is_settings, match;

  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      hv[i] = (cnt_r == CNT_W'(i)) ? rx_byte : head_r[i];
    end
  end

  assign cnt_inc    = (cnt_r < CNT_MAX) ? cnt_r + 5'd1 : CNT_MAX;
  assign recent_new = {recent_r[23:0], rx_byte};
  assign ended      = ((cnt_inc >= LEN_TERM2) && (recent_new[15:0] == TERM_SHORT)) ||
                      ((cnt_inc >= LEN_TERM4) && (recent_new == TERM_LONG));

  assign is_target   = (cnt_inc >= LEN_TYPE) && (hv[0] == HDR_TARGET) &&
                       (hv[1] == HDR_TARGET);
  assign is_settings = (cnt_inc >= LEN_SETTINGS) &&
                       (hv[0] == HDR_CMD0) && (hv[1] == HDR_CMD1) &&
                       (hv[2] == HDR_CMD2) && (hv[3] == HDR_CMD3) &&
                       (hv[6] == CMD_READ) && (hv[7] == CMD_ACK);

  always_comb begin
    rec   = '0;
    match = 1'b0;
    if (is_target) begin
      if (hv[2] == TYPE_NONE) begin
        match    = 1'b1;
        rec.kind = KIND_ABSENCE;
      end else if (((hv[2] == TYPE_MOVE) || (hv[2] == TYPE_STILL)) &&
                   (cnt_inc >= LEN_TARGET)) begin
        match        = 1'b1;
        rec.kind     = (hv[2] == TYPE_MOVE) ? KIND_MOVING : KIND_STATIONARY;
        rec.distance = {hv[4], hv[3]};
      end
    end else if (is_settings) begin
      match                 = 1'b1;
      rec.kind              = KIND_SETTINGS;
      rec.max_motion_gate   = {hv[11], hv[10]};
      rec.min_motion_gate   = {hv[13], hv[12]};
      rec.max_presence_gate = {hv[15], hv[14]};
      rec.min_presence_gate = {hv[17], hv[16]};
      rec.time_raw          = {hv[19], hv[18]};
    end
  end

  assign push = accept && ended && match;

  always_comb begin
    cnt_nxt    = cnt_r;
    recent_nxt = recent_r;
    if (accept) begin
      cnt_nxt    = ended ? '0 : cnt_inc;
      recent_nxt = ended ? '0 : recent_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      recent_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      recent_r <= recent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        head_r[i] <= hv[i];
      end
    end
  end

endmodule

@@ design/rpfp_queue.sv @@
// Short queue of classified frames between front and back end.
module rpfp_queue #(
  parameter int DEPTH = rpfp_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rpfp_pkg::rec_t        wr_rec,
  input  logic                  pop,
  output rpfp_pkg::rec_t        rd_rec,
  output rpfp_pkg::q_status_t   status
);
  import rpfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  rec_t               slot_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_QW-1:0]  cnt_r, cnt_nxt;

  assign status.valid = (cnt_r != '0);
  assign status.full  = (cnt_r == CNT_FULL);
  assign rd_rec       = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_rec;
    end
  end

endmodule

@@ design/rpfp_back.sv @@
// Back end: flag decode, divide-by-ten of the unoccupied time, output register.
module rpfp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rpfp_pkg::q_status_t          q_status,
  input  rpfp_pkg::rec_t               q_rec,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rpfp_pkg::KIND_W-1:0]  out_packet_kind,
  output logic                         out_presence,
  output logic                         out_motion,
  output logic [rpfp_pkg::WORD_W-1:0]  out_distance,
  output logic [rpfp_pkg::WORD_W-1:0]  out_max_motion_gate,
  output logic [rpfp_pkg::WORD_W-1:0]  out_min_motion_gate,
  output logic [rpfp_pkg::WORD_W-1:0]  out_max_presence_gate,
  output logic [rpfp_pkg::WORD_W-1:0]  out_min_presence_gate,
  output logic [rpfp_pkg::TIME_W-1:0]  out_unoccupied_time
);
  import rpfp_pkg::*;

  logic                    valid_r, valid_nxt;
  logic [2*WORD_W-1:0]     prod;
  rec_t                    rec_r;
  logic                    presence_r, motion_r;
  logic [TIME_W-1:0]       time_r;

  assign pop  = q_status.valid && (!valid_r || !out_stall);
  assign prod = q_rec.time_raw * DIV10_MUL;

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r      <= q_rec;
      presence_r <= (q_rec.kind == KIND_MOVING) || (q_rec.kind == KIND_STATIONARY);
      motion_r   <= (q_rec.kind == KIND_MOVING);
      time_r     <= prod[DIV10_SHIFT +: TIME_W];
    end
  end

  assign out_valid             = valid_r;
  assign out_packet_kind       = rec_r.kind;
  assign out_presence          = presence_r;
  assign out_motion            = motion_r;
  assign out_distance          = rec_r.distance;
  assign out_max_motion_gate   = rec_r.max_motion_gate;
  assign out_min_motion_gate   = rec_r.min_motion_gate;
  assign out_max_presence_gate = rec_r.max_presence_gate;
  assign out_min_presence_gate = rec_r.min_presence_gate;
  assign out_unoccupied_time   = time_r;

endmodule

@@ design/rpfp_checker.sv @@
// Port-level checks of the presence radar frame parser, bound to its top level.
module rpfp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rpfp_pkg::KIND_W-1:0]  out_packet_kind,
  input logic                         out_presence,
  input logic                         out_motion,
  input logic [rpfp_pkg::WORD_W-1:0]  out_distance,
  input logic [rpfp_pkg::WORD_W-1:0]  out_max_motion_gate,
  input logic [rpfp_pkg::WORD_W-1:0]  out_min_motion_gate,
  input logic [rpfp_pkg::WORD_W-1:0]  out_max_presence_gate,
  input logic [rpfp_pkg::WORD_W-1:0]  out_min_presence_gate,
  input logic [rpfp_pkg::TIME_W-1:0]  out_unoccupied_time
);
  import rpfp_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_packet_kind) && $stable(out_distance))
    else $error("stalled result changed");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_motion == (out_packet_kind == KIND_MOVING)) &&
                  (out_presence == ((out_packet_kind == KIND_MOVING) ||
                                    (out_packet_kind == KIND_STATIONARY))))
    else $error("presence or motion flag disagrees with kind");

  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_presence |-> out_distance == '0)
    else $error("distance set without a target");

  a_settings_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_packet_kind != KIND_SETTINGS) |->
      (out_max_motion_gate == '0) && (out_min_motion_gate == '0) &&
      (out_max_presence_gate == '0) && (out_min_presence_gate == '0) &&
      (out_unoccupied_time == '0))
    else $error("settings fields set outside a settings reply");

endmodule

bind radar_presence_frame_parser_unit rpfp_checker u_rpfp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_packet_kind       (out_packet_kind),
  .out_presence          (out_presence),
  .out_motion            (out_motion),
  .out_distance          (out_distance),
  .out_max_motion_gate   (out_max_motion_gate),
  .out_min_motion_gate   (out_min_motion_gate),
  .out_max_presence_gate (out_max_presence_gate),
  .out_min_presence_gate (out_min_presence_gate),
  .out_unoccupied_time   (out_unoccupied_time)
);
